@@ design/assert_macros.svh @@
// Shared assertion shorthands. Clock and reset names follow the house ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/isq_pkg.sv @@
package isq_pkg;

  localparam int MaxSegments = 32;
  localparam int ValueWidth  = 32;
  localparam int TagWidth    = 16;
  localparam int CountWidth  = $clog2(MaxSegments + 1);

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpBuild  = 2'd1,
    OpQuery  = 2'd2
  } isq_op_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusLocked = 2'd1,
    StatusFull   = 2'd2
  } isq_status_e;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [ValueWidth-1:0] seg_low;
    logic signed [ValueWidth-1:0] seg_high;
    logic [TagWidth-1:0]          seg_tag;
    logic signed [ValueWidth-1:0] query_point;
  } isq_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                match_valid;
    logic [TagWidth-1:0] match_tag;
    logic                last;
  } isq_out_t;

  // Hit flag and tag that ride the scan chain toward cell 0.
  typedef struct packed {
    logic                hit;
    logic [TagWidth-1:0] tag;
  } isq_scan_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic load;
    logic shift;
  } isq_ctrl_t;

endpackage

@@ design/isq_cell.sv @@
module isq_cell
  import isq_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  isq_ctrl_t                    ctrl_i,
  input  logic                         wr_i,
  input  logic                         occ_i,
  input  logic signed [ValueWidth-1:0] seg_low_i,
  input  logic signed [ValueWidth-1:0] seg_high_i,
  input  logic [TagWidth-1:0]          seg_tag_i,
  input  logic signed [ValueWidth-1:0] point_i,
  input  isq_scan_t                    scan_i,
  output isq_scan_t                    scan_o
);

  logic signed [ValueWidth-1:0] low_q, high_q;
  logic [TagWidth-1:0]          tag_q;
  isq_scan_t                    scan_q, scan_d;
  logic                         hit;

  // Segment slot: written once per insert, never cleared.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      low_q  <= seg_low_i;
      high_q <= seg_high_i;
      tag_q  <= seg_tag_i;
    end
  end

  assign hit = occ_i && (low_q <= point_i) && (point_i < high_q);

  always_comb begin
    scan_d = scan_q;
    if (ctrl_i.load) begin
      scan_d.hit = hit;
      scan_d.tag = tag_q;
    end else if (ctrl_i.shift) begin
      scan_d = scan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

@@ design/interval_stabbing_query.sv @@
// Segment stabbing table. Input channel (in_valid_i / in_stall_o / in_data_i)
// carries one operation per transfer: insert a half-open segment [low, high)
// with a tag, build (lock the table), or query a point. Output channel
// (out_valid_o / out_stall_i / out_data_o) returns the results; the final
// result of every input item has last set.
// Insert, build, a query on an open table and the unused code give one result,
// registered in the cycle after the transfer. A query on a locked table loads
// the hit flags of all cells at once, then walks the cell chain toward cell 0,
// one cell per cycle while the receiver does not stall a pending hit, and
// emits one result per hit in load order, or one empty result when nothing
// hits. Only one item is in flight: in_stall_o stays high during a scan.
// The output register holds a result while out_stall_i is high, and a new
// item is taken in the same cycle the waiting result is transferred.
// Reset clears the entry count, the lock, the scan flags and the output
// valid; segment slots keep no reset value and are never read before written.
module interval_stabbing_query
  import isq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  isq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output isq_out_t out_data_o
);

`include "assert_macros.svh"

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e                state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  locked_q, locked_d;
  logic                  out_valid_q, out_valid_d;
  isq_out_t              out_q, out_d;

  logic                  accept, out_free, full, insert_ok;
  isq_op_e               op;
  isq_ctrl_t             ctrl;
  logic [MaxSegments-1:0] occ, wr_sel, hit_vec;
  isq_scan_t             scan [MaxSegments];
  isq_scan_t             scan_head;
  logic                  rest_hit;

  assign op       = isq_op_e'(in_data_i.operation);
  assign out_free = !out_valid_q || !out_stall_i;
  // Take a new item only when idle and the output slot can take its result.
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CountWidth'(MaxSegments));
  assign insert_ok = accept && (op == OpInsert) && !locked_q && !full;

  // Cell chain: cell i holds segment i and hands its scan pair to cell i-1.
  for (genvar i = 0; i < MaxSegments; i++) begin : g_cell
    isq_scan_t scan_in;

    assign occ[i]     = (count_q > CountWidth'(i));
    assign wr_sel[i]  = insert_ok && (count_q == CountWidth'(i));
    assign hit_vec[i] = scan[i].hit;

    if (i == MaxSegments - 1) begin : g_tail
      assign scan_in = '0;
    end else begin : g_link
      assign scan_in = scan[i+1];
    end

    isq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_i       (wr_sel[i]),
      .occ_i      (occ[i]),
      .seg_low_i  (in_data_i.seg_low),
      .seg_high_i (in_data_i.seg_high),
      .seg_tag_i  (in_data_i.seg_tag),
      .point_i    (in_data_i.query_point),
      .scan_i     (scan_in),
      .scan_o     (scan[i])
    );
  end

  assign scan_head = scan[0];
  // Any hit still waiting behind the head of the chain.
  assign rest_hit  = |(hit_vec >> 1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    locked_d    = locked_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctrl        = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          // Default result: empty, ok, last.
          out_valid_d       = 1'b1;
          out_d.status      = StatusOk;
          out_d.match_valid = 1'b0;
          out_d.match_tag   = '0;
          out_d.last        = 1'b1;
          unique case (op)
            OpInsert: begin
              if (locked_q) begin
                out_d.status = StatusLocked;
              end else if (full) begin
                out_d.status = StatusFull;
              end else begin
                count_d = count_q + CountWidth'(1);
              end
            end
            OpBuild: begin
              locked_d = 1'b1;
            end
            OpQuery: begin
              if (locked_q) begin
                // Hold the result back; the scan produces it.
                out_valid_d = out_valid_q && out_stall_i;
                out_d       = out_q;
                ctrl.load   = 1'b1;
                state_d     = StScan;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        if (scan_head.hit) begin
          if (out_free) begin
            out_valid_d       = 1'b1;
            out_d.status      = StatusOk;
            out_d.match_valid = 1'b1;
            out_d.match_tag   = scan_head.tag;
            out_d.last        = !rest_hit;
            ctrl.shift        = 1'b1;
            if (!rest_hit) begin
              state_d = StIdle;
            end
          end
        end else if (rest_hit) begin
          // Advance past a cell with no hit.
          ctrl.shift = 1'b1;
        end else if (out_free) begin
          // No hit anywhere in the chain: one empty result.
          out_valid_d       = 1'b1;
          out_d.status      = StatusOk;
          out_d.match_valid = 1'b0;
          out_d.match_tag   = '0;
          out_d.last        = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      locked_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      locked_q    <= locked_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Once locked, the table never grows again.
  `ASSERT_CHK(a_locked_count_stable, locked_q |=> $stable(count_q), "count changed while locked")
  // The entry count stays within the table.
  `ASSERT_NEVER(a_count_range, count_q > CountWidth'(MaxSegments), "entry count overflow")
  // No new item enters while a scan is running.
  `ASSERT_NEVER(a_no_accept_in_scan, (state_q == StScan) && accept, "accept during scan")
  // A scan result marked last ends the scan.
  `ASSERT_CHK(a_last_ends_scan, ((state_q == StScan) && ctrl.shift && !rest_hit && scan_head.hit) |=> (state_q == StIdle), "scan did not end after last hit")

endmodule

@@ sim/isq_stab_checker.sv @@
`timescale 1ns / 100ps

module isq_stab_checker
  import isq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  isq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  isq_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int PrintCap = 60;

  typedef logic signed [ValueWidth-1:0] coord_t;

  coord_t              seg_lo_mem  [MaxSegments];
  coord_t              seg_hi_mem  [MaxSegments];
  logic [TagWidth-1:0] seg_tag_mem [MaxSegments];
  int                  seg_count    = 0;
  logic                table_locked = 1'b0;
  int                  mismatches   = 0;
  isq_out_t            stab_result_q [$];

  task automatic report_mismatch(input string what, input isq_out_t got, input isq_out_t want);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("%0t %s: got st=%0d v=%0b tag=%h last=%0b, want st=%0d v=%0b tag=%h last=%0b",
               $realtime, what, got.status, got.match_valid, got.match_tag, got.last,
               want.status, want.match_valid, want.match_tag, want.last);
    end
  endtask

  // Append one expected result at the tail of the pending list.
  function automatic void enqueue_result(input isq_out_t res);
    stab_result_q.insert(stab_result_q.size(), res);
  endfunction

  // Work out every result one accepted item causes, in load order.
  task automatic predict_stab(input isq_in_t item);
    isq_out_t res;
    coord_t   pt;
    int       hits;
    res        = '0;
    res.status = StatusOk;
    res.last   = 1'b1;
    if (item.operation == OpInsert) begin
      if (table_locked) begin
        res.status = StatusLocked;
      end else if (seg_count >= MaxSegments) begin
        res.status = StatusFull;
      end else begin
        seg_lo_mem[seg_count]  = item.seg_low;
        seg_hi_mem[seg_count]  = item.seg_high;
        seg_tag_mem[seg_count] = item.seg_tag;
        seg_count++;
      end
    end else if (item.operation == OpBuild) begin
      table_locked = 1'b1;
    end else if (item.operation == OpQuery && table_locked) begin
      pt   = item.query_point;
      hits = 0;
      for (int i = 0; i < seg_count; i++) begin
        if (seg_lo_mem[i] <= pt && pt < seg_hi_mem[i]) begin
          res.match_valid = 1'b1;
          res.match_tag   = seg_tag_mem[i];
          res.last        = 1'b0;
          enqueue_result(res);
          hits++;
        end
      end
      if (hits > 0) begin
        // Mark the final hit of this query.
        res      = stab_result_q.pop_back();
        res.last = 1'b1;
        enqueue_result(res);
        return;
      end
    end
    enqueue_result(res);
  endtask

  task automatic check_result(input isq_out_t got);
    isq_out_t want;
    if (stab_result_q.size() == 0) begin
      report_mismatch("result with nothing pending", got, '0);
      return;
    end
    want = stab_result_q.pop_front();
    if (got.status !== want.status) report_mismatch("status", got, want);
    if (got.match_valid !== want.match_valid) report_mismatch("match_valid", got, want);
    if (got.match_tag !== want.match_tag) report_mismatch("match_tag", got, want);
    if (got.last !== want.last) report_mismatch("last", got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict_stab(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= stab_result_q.size();
  end

endmodule

@@ sim/tb_interval_stabbing_query.sv @@
`timescale 1ns / 100ps

module tb_interval_stabbing_query;
  import isq_pkg::*;

  localparam int         ClkPeriod   = 20;
  localparam int         ResetCycles = 8;
  localparam int         ItemTarget  = 380;
  localparam int         DrainCycles = 40;
  localparam int         CycleLimit  = 3_000_000;
  // Operation code the block has no name for; it must give one empty result.
  localparam logic [1:0] OpUnused    = 2'd3;

  typedef logic signed [ValueWidth-1:0] coord_t;

  localparam coord_t CoordMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam coord_t CoordMax = {1'b0, {(ValueWidth-1){1'b1}}};

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_valid   = 1'b0;
  logic     in_stall;
  isq_in_t  in_data    = '0;
  logic     out_valid;
  logic     out_stall  = 1'b0;
  isq_out_t out_data;
  int       fail_count;
  int       pending;
  int       items_sent = 0;
  int       cycle_count = 0;
  // Inserts sent through send_insert, refused and locked ones included.
  int       open_inserts = 0;
  // Stretches where one side never idles.
  logic     quiet_src  = 1'b0;
  logic     quiet_sink = 1'b0;
  // Segment ends seen so far; queries aimed at them land on the boundaries.
  coord_t   probe_q [$];

  interval_stabbing_query u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  isq_stab_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Mostly zero, often a few cycles, now and then a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Small coordinates around zero, so that segments overlap and queries hit.
  function automatic coord_t near_coord();
    return $signed($urandom_range(0, 300)) - 150;
  endfunction

  // Fill every field at random, so that fields the operation ignores toggle too.
  function automatic isq_in_t noise_item(input logic [1:0] op);
    isq_in_t item;
    item.operation   = op;
    item.seg_low     = $urandom();
    item.seg_high    = $urandom();
    item.seg_tag     = TagWidth'($urandom());
    item.query_point = $urandom();
    return item;
  endfunction

  // Remember one coordinate as a query target.
  function automatic void add_probe(input coord_t v);
    probe_q.insert(probe_q.size(), v);
  endfunction

  function automatic coord_t pick_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return probe_q[$urandom_range(0, probe_q.size() - 1)];
    if (r < 80) return near_coord();
    if (r < 95) return $urandom();
    return ($urandom_range(0, 1) != 0) ? CoordMin : CoordMax;
  endfunction

  // Present one item and hold it until the block takes it. Drop valid only
  // when a gap comes first, so valid sees one assignment per time step.
  task automatic drive_item(input isq_in_t item);
    int gap;
    gap = quiet_src ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= noise_item(2'($urandom()));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_insert(input coord_t lo, input coord_t hi,
                             input logic [TagWidth-1:0] tag);
    isq_in_t item;
    item          = noise_item(OpInsert);
    item.seg_low  = lo;
    item.seg_high = hi;
    item.seg_tag  = tag;
    add_probe(lo);
    add_probe(hi);
    add_probe(hi - 1);
    add_probe(lo - 1);
    open_inserts++;
    drive_item(item);
  endtask

  // Mostly short local segments, some arbitrary, some covering nearly all.
  task automatic send_random_insert();
    coord_t lo;
    coord_t hi;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      lo = near_coord();
      hi = lo + $urandom_range(0, 120);
    end else if (r < 80) begin
      lo = $urandom();
      hi = $urandom();
    end else begin
      lo = CoordMin + $urandom_range(0, 9);
      hi = CoordMax - $urandom_range(0, 9);
    end
    send_insert(lo, hi, TagWidth'($urandom()));
  endtask

  task automatic send_query(input coord_t pt);
    isq_in_t item;
    item             = noise_item(OpQuery);
    item.query_point = pt;
    drive_item(item);
  endtask

  task automatic send_plain(input logic [1:0] op);
    drive_item(noise_item(op));
  endtask

  // Receiver: open windows of random length, then stall for a while.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(1, quiet_sink ? 150 : 10)) @(posedge clk);
      if (!quiet_sink) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Bail out if the block hangs or a result never shows up.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int r;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Open table: a query before build must come back empty, as must the
    // unused code.
    send_query(0);
    send_plain(OpUnused);
    // Extreme ends, one-point segments at both ends of the range, an empty
    // and two inverted segments, and a repeated tag on the same segment.
    send_insert(CoordMin, CoordMax, 16'hFFFF);
    send_insert(CoordMin, CoordMin + 1, 16'h0000);
    send_insert(CoordMax - 1, CoordMax, 16'hAAAA);
    send_insert(5, 5, 16'h5555);
    send_insert(10, -10, 16'h0001);
    send_insert(CoordMax, CoordMin, 16'h8000);
    send_insert(0, 100, 16'h1234);
    send_insert(0, 100, 16'h1234);
    send_insert(-100, 1, 16'h0007);
    send_query(0);

    // Fill to capacity and push a few past it; those must be refused as full.
    while (open_inserts < MaxSegments + 4) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_random_insert();
      else if (r < 90) send_query(pick_point());
      else send_plain(OpUnused);
    end

    // Lock twice, then an insert that must be refused as locked.
    send_plain(OpBuild);
    send_plain(OpBuild);
    send_random_insert();
    send_plain(OpUnused);

    // Boundary queries on the locked table.
    send_query(CoordMin);
    send_query(CoordMin + 1);
    send_query(CoordMax);
    send_query(CoordMax - 1);
    send_query(-1);
    send_query(0);
    send_query(5);
    send_query(10);
    send_query(99);
    send_query(100);

    // Random part: mostly queries, the rest locked inserts, rebuilds and the
    // unused code. Reshuffle the idle modes every so often.
    while (items_sent < ItemTarget) begin
      if (items_sent % 50 == 0) begin
        quiet_src  = ($urandom_range(0, 3) == 0);
        quiet_sink = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 80) send_query(pick_point());
      else if (r < 88) send_plain(OpInsert);
      else if (r < 94) send_plain(OpBuild);
      else send_plain(OpUnused);
    end
    in_valid <= 1'b0;

    // Let the last transfer reach the checker, drain, then give stray
    // results a chance to show up.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
